@@ src/irit_pkg.sv @@
package irit_pkg;

   localparam int TIME_WIDTH  = 63;
   localparam int FIELD_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOWER_BOUND  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UPPER_BOUND  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_DURATION = 2'd2;

   // Result kinds.
   localparam logic KIND_RUN_REPORT = 1'b0;
   localparam logic KIND_SUMMARY    = 1'b1;

   typedef struct packed {
      logic                   report_kind;
      logic                   last_of_run;
      logic [FIELD_WIDTH-1:0] run_number;
      logic [TIME_WIDTH-1:0]  run_begin_time;
      logic [TIME_WIDTH-1:0]  run_end_time;
      logic [FIELD_WIDTH-1:0] run_sample_count;
      logic [TIME_WIDTH-1:0]  sum_all_durations;
      logic [TIME_WIDTH-1:0]  sum_qualified_durations;
      logic [FIELD_WIDTH-1:0] sum_all_in_range;
      logic [FIELD_WIDTH-1:0] sum_qualified_in_range;
      logic [FIELD_WIDTH-1:0] samples_seen;
   } result_type;

   // Up to two results that one sample produces, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } batch_type;

   // Saturating add of two durations at the full time width.
   function automatic logic [TIME_WIDTH-1:0] sat_add_time(
      input logic [TIME_WIDTH-1:0] a,
      input logic [TIME_WIDTH-1:0] b
   );
      logic [TIME_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
   endfunction

endpackage

@@ src/in_range_interval_tracker_top.sv @@
// A sample's results are offered from the result buffer, which is loaded from the core
// while the sample sits in the input register. Throughput: one sample per cycle while
// rsp_ready stays high; a sample ending a qualifying run on the last sample gives two
// results, and the two-entry result buffer then holds the next sample back until the first has left.
// Reset is synchronous and active high; it clears the run state, totals, the
// configuration registers and both handshake stages.
module in_range_interval_tracker_top #(
   parameter int COUNT_WIDTH  = 32,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [irit_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [irit_pkg::FIELD_WIDTH-1:0]        csr_data,

   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [SAMPLE_WIDTH-1:0]                 req_sample_value,
   input  logic [irit_pkg::TIME_WIDTH-1:0]         req_sample_time,
   input  logic                                    req_end_of_stream,

   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_report_kind,
   output logic                                    rsp_last_of_run,
   output logic [irit_pkg::FIELD_WIDTH-1:0]        rsp_run_number,
   output logic [irit_pkg::TIME_WIDTH-1:0]         rsp_run_begin_time,
   output logic [irit_pkg::TIME_WIDTH-1:0]         rsp_run_end_time,
   output logic [irit_pkg::FIELD_WIDTH-1:0]        rsp_run_sample_count,
   output logic [irit_pkg::TIME_WIDTH-1:0]         rsp_sum_all_durations,
   output logic [irit_pkg::TIME_WIDTH-1:0]         rsp_sum_qualified_durations,
   output logic [irit_pkg::FIELD_WIDTH-1:0]        rsp_sum_all_in_range,
   output logic [irit_pkg::FIELD_WIDTH-1:0]        rsp_sum_qualified_in_range,
   output logic [irit_pkg::FIELD_WIDTH-1:0]        rsp_samples_seen
);
   import irit_pkg::*;

   // Configuration registers. Writes are always taken; an index past the last
   // register completes its transfer and changes nothing.
   logic [FIELD_WIDTH-1:0] lower_ff, upper_ff, min_dur_ff;
   logic                   csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff   <= '0;
         upper_ff   <= '0;
         min_dur_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LOWER_BOUND:  lower_ff   <= csr_data;
            REG_UPPER_BOUND:  upper_ff   <= csr_data;
            REG_MIN_DURATION: min_dur_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The sample sits in the input register while the core evaluates it. It moves
   // on, and the run state and totals update, in the same cycle that its results
   // are loaded into the result buffer.
   logic                    item_valid, item_last, can_load, advance;
   logic [SAMPLE_WIDTH-1:0] item_value;
   logic [TIME_WIDTH-1:0]   item_time;
   batch_type               batch;
   result_type              rsp_result;

   assign advance = item_valid && can_load;

   irit_in_stage #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_in_stage (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_value  (req_sample_value),
      .req_sample_time   (req_sample_time),
      .req_end_of_stream (req_end_of_stream),
      .advance           (advance),
      .item_valid        (item_valid),
      .item_value        (item_value),
      .item_time         (item_time),
      .item_last         (item_last)
   );

   irit_core #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .lower_bound  (lower_ff),
      .upper_bound  (upper_ff),
      .min_duration (min_dur_ff),
      .advance      (advance),
      .item_value   (item_value),
      .item_time    (item_time),
      .item_last    (item_last),
      .batch        (batch)
   );

   // The result buffer holds a whole batch, so a stalled consumer never blocks
   // the core in the middle of a sample.
   irit_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .batch      (batch),
      .can_load   (can_load),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_report_kind             = rsp_result.report_kind;
   assign rsp_last_of_run             = rsp_result.last_of_run;
   assign rsp_run_number              = rsp_result.run_number;
   assign rsp_run_begin_time          = rsp_result.run_begin_time;
   assign rsp_run_end_time            = rsp_result.run_end_time;
   assign rsp_run_sample_count        = rsp_result.run_sample_count;
   assign rsp_sum_all_durations       = rsp_result.sum_all_durations;
   assign rsp_sum_qualified_durations = rsp_result.sum_qualified_durations;
   assign rsp_sum_all_in_range        = rsp_result.sum_all_in_range;
   assign rsp_sum_qualified_in_range  = rsp_result.sum_qualified_in_range;
   assign rsp_samples_seen            = rsp_result.samples_seen;

endmodule

@@ src/irit_in_stage.sv @@
module irit_in_stage #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [SAMPLE_WIDTH-1:0]       req_sample_value,
   input  logic [irit_pkg::TIME_WIDTH-1:0] req_sample_time,
   input  logic                          req_end_of_stream,
   input  logic                          advance,
   output logic                          item_valid,
   output logic [SAMPLE_WIDTH-1:0]       item_value,
   output logic [irit_pkg::TIME_WIDTH-1:0] item_time,
   output logic                          item_last
);
   import irit_pkg::*;

   logic                    valid_ff, valid_in;
   logic [SAMPLE_WIDTH-1:0] value_ff;
   logic [TIME_WIDTH-1:0]   time_ff;
   logic                    last_ff;
   logic                    take;

   // The register frees up in the same cycle that its item moves on.
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         value_ff <= req_sample_value;
         time_ff  <= req_sample_time;
         last_ff  <= req_end_of_stream;
      end
   end

   assign item_valid = valid_ff;
   assign item_value = value_ff;
   assign item_time  = time_ff;
   assign item_last  = last_ff;

endmodule

@@ src/irit_core.sv @@
module irit_core #(
   parameter int COUNT_WIDTH  = 32,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [irit_pkg::FIELD_WIDTH-1:0]   lower_bound,
   input  logic [irit_pkg::FIELD_WIDTH-1:0]   upper_bound,
   input  logic [irit_pkg::FIELD_WIDTH-1:0]   min_duration,
   input  logic                               advance,
   input  logic [SAMPLE_WIDTH-1:0]            item_value,
   input  logic [irit_pkg::TIME_WIDTH-1:0]    item_time,
   input  logic                               item_last,
   output irit_pkg::batch_type                batch
);
   import irit_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic                   inside_ff, inside_in;
   logic [TIME_WIDTH-1:0]  open_time_ff, open_time_in;
   logic [COUNT_WIDTH-1:0] open_count_ff, open_count_in;
   logic [COUNT_WIDTH-1:0] qual_runs_ff, qual_runs_in;
   logic [TIME_WIDTH-1:0]  all_dur_ff, all_dur_in;
   logic [TIME_WIDTH-1:0]  qual_dur_ff, qual_dur_in;
   logic [COUNT_WIDTH-1:0] all_in_ff, all_in_in;
   logic [COUNT_WIDTH-1:0] qual_in_ff, qual_in_in;
   logic [COUNT_WIDTH-1:0] samples_ff, samples_in;

   logic [SAMPLE_WIDTH-1:0] lo_s, hi_s;
   logic                    hit, closing, qual;
   logic [COUNT_WIDTH-1:0]  base_count, run_count;
   logic [TIME_WIDTH-1:0]   run_time, dur;
   logic [TIME_WIDTH:0]     diff;
   logic [COUNT_WIDTH:0]    all_in_sum, qual_in_sum;
   logic [COUNT_WIDTH-1:0]  all_in_next, qual_in_next, qual_runs_next, samples_next;
   logic [TIME_WIDTH-1:0]   all_dur_next, qual_dur_next;
   result_type              report, summary;

   // Bounds are zero-extended or truncated to the sample width, then compared signed.
   assign lo_s = SAMPLE_WIDTH'(lower_bound);
   assign hi_s = SAMPLE_WIDTH'(upper_bound);
   assign hit  = ($signed(item_value) >= $signed(lo_s)) &&
                 ($signed(item_value) <= $signed(hi_s));

   // A sample in range either extends the open run or opens one at its own time.
   assign base_count = inside_ff ? open_count_ff : '0;
   assign run_count  = hit ? ((base_count == COUNT_MAX) ? base_count : base_count + COUNT_ONE)
                           : open_count_ff;
   assign run_time   = (hit && !inside_ff) ? item_time : open_time_ff;
   assign closing    = (hit && item_last) || (!hit && inside_ff);

   // Time running backwards gives a zero duration.
   assign diff = {1'b0, item_time} - {1'b0, run_time};
   assign dur  = diff[TIME_WIDTH] ? '0 : diff[TIME_WIDTH-1:0];
   assign qual = closing && (dur >= TIME_WIDTH'(min_duration));

   assign all_in_sum  = {1'b0, all_in_ff} + {1'b0, run_count};
   assign qual_in_sum = {1'b0, qual_in_ff} + {1'b0, run_count};

   always_comb begin
      all_dur_next   = closing ? sat_add_time(all_dur_ff, dur) : all_dur_ff;
      all_in_next    = all_in_ff;
      qual_dur_next  = qual_dur_ff;
      qual_in_next   = qual_in_ff;
      qual_runs_next = qual_runs_ff;
      if (closing) begin
         all_in_next = all_in_sum[COUNT_WIDTH] ? COUNT_MAX : all_in_sum[COUNT_WIDTH-1:0];
      end
      if (qual) begin
         qual_dur_next  = sat_add_time(qual_dur_ff, dur);
         qual_in_next   = qual_in_sum[COUNT_WIDTH] ? COUNT_MAX
                                                   : qual_in_sum[COUNT_WIDTH-1:0];
         qual_runs_next = (qual_runs_ff == COUNT_MAX) ? qual_runs_ff
                                                      : qual_runs_ff + COUNT_ONE;
      end
      samples_next = (samples_ff == COUNT_MAX) ? samples_ff : samples_ff + COUNT_ONE;
   end

   always_comb begin
      report                  = '0;
      report.report_kind      = KIND_RUN_REPORT;
      report.last_of_run      = !item_last;
      report.run_number       = FIELD_WIDTH'(qual_runs_next);
      report.run_begin_time   = run_time;
      report.run_end_time     = item_time;
      report.run_sample_count = FIELD_WIDTH'(run_count);

      summary                         = '0;
      summary.report_kind             = KIND_SUMMARY;
      summary.last_of_run             = 1'b1;
      summary.run_number              = FIELD_WIDTH'(qual_runs_next);
      summary.sum_all_durations       = all_dur_next;
      summary.sum_qualified_durations = qual_dur_next;
      summary.sum_all_in_range        = FIELD_WIDTH'(all_in_next);
      summary.sum_qualified_in_range  = FIELD_WIDTH'(qual_in_next);
      summary.samples_seen            = FIELD_WIDTH'(samples_next);

      batch.count  = {1'b0, qual} + {1'b0, item_last};
      batch.first  = qual ? report : summary;
      batch.second = summary;
   end

   always_comb begin
      if (item_last) begin
         inside_in     = 1'b0;
         open_time_in  = '0;
         open_count_in = '0;
         qual_runs_in  = '0;
         all_dur_in    = '0;
         qual_dur_in   = '0;
         all_in_in     = '0;
         qual_in_in    = '0;
         samples_in    = '0;
      end else begin
         inside_in     = hit;
         open_time_in  = hit ? run_time : '0;
         open_count_in = hit ? run_count : '0;
         qual_runs_in  = qual_runs_next;
         all_dur_in    = all_dur_next;
         qual_dur_in   = qual_dur_next;
         all_in_in     = all_in_next;
         qual_in_in    = qual_in_next;
         samples_in    = samples_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff     <= 1'b0;
         open_time_ff  <= '0;
         open_count_ff <= '0;
         qual_runs_ff  <= '0;
         all_dur_ff    <= '0;
         qual_dur_ff   <= '0;
         all_in_ff     <= '0;
         qual_in_ff    <= '0;
         samples_ff    <= '0;
      end else if (advance) begin
         inside_ff     <= inside_in;
         open_time_ff  <= open_time_in;
         open_count_ff <= open_count_in;
         qual_runs_ff  <= qual_runs_in;
         all_dur_ff    <= all_dur_in;
         qual_dur_ff   <= qual_dur_in;
         all_in_ff     <= all_in_in;
         qual_in_ff    <= qual_in_in;
         samples_ff    <= samples_in;
      end
   end

endmodule

@@ src/irit_out_buf.sv @@
module irit_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  irit_pkg::batch_type  batch,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output irit_pkg::result_type rsp_result
);
   import irit_pkg::*;

   logic [1:0] count_ff, count_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       pop;

   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_result = slot0_ff;
   assign pop        = rsp_valid && rsp_ready;

   // A new batch may enter once everything held here leaves this cycle.
   assign can_load = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         count_in = batch.count;
         slot0_in = batch.first;
         slot1_in = batch.second;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule
